### rtl/brsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-range spec parser package
// Request and result types, result kinds, prefix text and queue sizing.
// ----------------------------------------------------------------------------
package brsp_pkg;

	localparam int OFFSET_WIDTH_DEF = 63;
	localparam int OUT_OFFSET_W     = 63;
	localparam int PREFIX_LEN       = 6;
	localparam int QUEUE_DEPTH      = 4;

	typedef logic [OUT_OFFSET_W-1:0] offset_t;

	localparam logic [1:0] KIND_RANGE  = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	localparam logic [7:0] CH_DASH  = 8'h2d;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CASE_BIT = 8'h20;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} req_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic       start_present;
		offset_t    start_offset;
		logic       stop_present;
		offset_t    stop_offset;
		logic       last_result;
	} rsp_t;

	// up to two results from one request
	typedef struct packed {
		logic [1:0] n;
		rsp_t       r0;
		rsp_t       r1;
	} push_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0:    ch = 8'h62; // b
			3'd1:    ch = 8'h79; // y
			3'd2:    ch = 8'h74; // t
			3'd3:    ch = 8'h65; // e
			3'd4:    ch = 8'h73; // s
			3'd5:    ch = 8'h3d; // =
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

### rtl/brsp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-range spec parser: parse stage
// Prefix match, range phase tracking, saturating decimal accumulators.
// ----------------------------------------------------------------------------
module brsp_parse #(
	parameter int OFFSET_WIDTH = brsp_pkg::OFFSET_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  brsp_pkg::req_t   req,
	output brsp_pkg::push_t  push
);

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_START,
		PH_TAIL,
		PH_FIRST,
		PH_DASHED,
		PH_SECOND,
		PH_ERROR
	} phase_t;

	localparam int SUM_W = OFFSET_WIDTH + 4;
	localparam logic [OFFSET_WIDTH-1:0] ACC_MAX = {OFFSET_WIDTH{1'b1}};

	phase_t                  phase_q, phase_d;
	logic [2:0]              pos_q, pos_d;
	logic [OFFSET_WIDTH-1:0] start_acc_q, start_acc_d;
	logic [OFFSET_WIDTH-1:0] stop_acc_q, stop_acc_d;
	logic                    start_seen_q, start_seen_d;
	logic                    stop_seen_q, stop_seen_d;

	logic [7:0]              ch, lc;
	logic                    is_digit, is_dash, is_comma, err;
	logic [3:0]              dig;
	logic [SUM_W-1:0]        start_sum, stop_sum;
	logic [OFFSET_WIDTH-1:0] start_next, stop_next;
	brsp_pkg::rsp_t          rng, rej, acc_res;

	assign ch       = req.text_byte;
	assign lc       = (ch >= brsp_pkg::CH_UP_A && ch <= brsp_pkg::CH_UP_Z) ?
	                  (ch | brsp_pkg::CASE_BIT) : ch;
	assign is_digit = ch >= brsp_pkg::CH_ZERO && ch <= brsp_pkg::CH_NINE;
	assign is_dash  = ch == brsp_pkg::CH_DASH;
	assign is_comma = ch == brsp_pkg::CH_COMMA;
	assign dig      = is_digit ? 4'(ch - brsp_pkg::CH_ZERO) : 4'd0;

	// acc*10 + d, saturating
	assign start_sum = {1'b0, start_acc_q, 3'b000} + {3'b000, start_acc_q, 1'b0} +
	                   SUM_W'(dig);
	assign stop_sum  = {1'b0, stop_acc_q, 3'b000} + {3'b000, stop_acc_q, 1'b0} +
	                   SUM_W'(dig);
	assign start_next = (start_sum > {4'b0000, ACC_MAX}) ? ACC_MAX :
	                    start_sum[OFFSET_WIDTH-1:0];
	assign stop_next  = (stop_sum > {4'b0000, ACC_MAX}) ? ACC_MAX :
	                    stop_sum[OFFSET_WIDTH-1:0];

	always_comb begin
		rng               = '0;
		rng.result_kind   = brsp_pkg::KIND_RANGE;
		rng.start_present = start_seen_q;
		rng.start_offset  = start_seen_q ? brsp_pkg::offset_t'(start_acc_q) : '0;
		rng.stop_present  = stop_seen_q;
		rng.stop_offset   = stop_seen_q ? brsp_pkg::offset_t'(stop_acc_q) : '0;
		rej               = '0;
		rej.result_kind   = brsp_pkg::KIND_REJECT;
		rej.last_result   = 1'b1;
		acc_res             = '0;
		acc_res.result_kind = brsp_pkg::KIND_ACCEPT;
		acc_res.last_result = 1'b1;
	end

	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		start_acc_d  = start_acc_q;
		stop_acc_d   = stop_acc_q;
		start_seen_d = start_seen_q;
		stop_seen_d  = stop_seen_q;
		push         = '0;
		err          = 1'b0;
		if (go) begin
			if (req.end_of_text) begin
				if (phase_q == PH_DASHED || phase_q == PH_SECOND) begin
					push.n  = 2'd2;
					push.r0 = rng;
					push.r1 = acc_res;
				end else if (phase_q != PH_ERROR) begin
					push.n  = 2'd1;
					push.r0 = rej;
				end
				phase_d      = PH_PREFIX;
				pos_d        = '0;
				start_acc_d  = '0;
				stop_acc_d   = '0;
				start_seen_d = 1'b0;
				stop_seen_d  = 1'b0;
			end else begin
				unique case (phase_q)
					PH_PREFIX: begin
						if (pos_q < 3'(brsp_pkg::PREFIX_LEN) &&
						    lc == brsp_pkg::prefix_char(pos_q)) begin
							pos_d = pos_q + 3'd1;
							if (pos_q == 3'(brsp_pkg::PREFIX_LEN - 1))
								phase_d = PH_START;
						end else begin
							err = 1'b1;
						end
					end
					PH_START: begin
						start_acc_d  = '0;
						stop_acc_d   = '0;
						start_seen_d = 1'b0;
						stop_seen_d  = 1'b0;
						if (is_dash) begin
							phase_d = PH_TAIL;
						end else if (is_digit) begin
							start_seen_d = 1'b1;
							start_acc_d  = OFFSET_WIDTH'(dig);
							phase_d      = PH_FIRST;
						end else begin
							err = 1'b1;
						end
					end
					PH_TAIL: begin
						if (is_digit) begin
							stop_seen_d = 1'b1;
							stop_acc_d  = OFFSET_WIDTH'(dig);
							phase_d     = PH_SECOND;
						end else begin
							err = 1'b1;
						end
					end
					PH_FIRST: begin
						if (is_dash)
							phase_d = PH_DASHED;
						else if (is_digit)
							start_acc_d = start_next;
						else
							err = 1'b1;
					end
					PH_DASHED, PH_SECOND: begin
						if (is_comma) begin
							push.n                = 2'd1;
							push.r0               = rng;
							push.r0.last_result   = 1'b1;
							start_acc_d           = '0;
							stop_acc_d            = '0;
							start_seen_d          = 1'b0;
							stop_seen_d           = 1'b0;
							phase_d               = PH_START;
						end else if (is_digit) begin
							if (phase_q == PH_DASHED) begin
								stop_seen_d = 1'b1;
								stop_acc_d  = OFFSET_WIDTH'(dig);
								phase_d     = PH_SECOND;
							end else begin
								stop_acc_d = stop_next;
							end
						end else begin
							err = 1'b1;
						end
					end
					PH_ERROR: ;
					default: err = 1'b1;
				endcase
				if (err) begin
					phase_d = PH_ERROR;
					push.n  = 2'd1;
					push.r0 = rej;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PREFIX;
			pos_q        <= '0;
			start_acc_q  <= '0;
			stop_acc_q   <= '0;
			start_seen_q <= 1'b0;
			stop_seen_q  <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			pos_q        <= pos_d;
			start_acc_q  <= start_acc_d;
			stop_acc_q   <= stop_acc_d;
			start_seen_q <= start_seen_d;
			stop_seen_q  <= stop_seen_d;
		end
	end

`ifndef ASSERT_OFF
	a_pair_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> go && req.end_of_text)
		else $error("two results without end of text");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		go && req.end_of_text |=> phase_q == PH_PREFIX && pos_q == 3'd0 &&
		!start_seen_q && !stop_seen_q)
		else $error("end of text did not reset parser");

	a_error_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR && !req.end_of_text |-> push.n == 2'd0)
		else $error("result after error");
`endif

endmodule

### rtl/brsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-range spec parser: result queue
// Small queue taking up to two results a cycle and giving one a cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module brsp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  brsp_pkg::push_t  push,
	output logic             room,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output brsp_pkg::rsp_t   rsp
);

	localparam int PTR_W = $clog2(brsp_pkg::QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	brsp_pkg::rsp_t   mem [brsp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign rsp_valid = count_q != '0;
	assign rsp       = mem[rd_q];
	assign pop       = rsp_valid && !rsp_stall;
	assign room      = count_q <= CNT_W'(brsp_pkg::QUEUE_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem[wr_q] <= push.r0;
		if (push.n == 2'd2)
			mem[wr_q + PTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.n);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push without room");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(brsp_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r1.last_result && !push.r0.last_result)
		else $error("bad last flags on result pair");
`endif

endmodule

### rtl/byte_range_spec_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-range spec parser core
// Parses a "bytes=" range value one character per request into range results.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one character per request (req_valid / req_stall), with
//   end_of_text set on a closing request that ends the value.
//  rsp channel: range entries, then an accepted or rejected status
//   (rsp_valid / rsp_stall); last_result marks the final result of a request.
//  Path: a taken request is held in the input register, then parsed and
//   written into the result queue, from which its first result is offered
//   on rsp.
//  Throughput: one request per cycle while req_stall is low; the end request yields up to two
//   results, drained one per cycle while rsp_stall is low from a four-entry result queue.
//  Stall: req_stall rises when a request is held and the queue cannot take two more results;
//   the held request waits in the input register.
//  Reset: parser returns to prefix matching, the queue empties. After an
//   error the parser drops characters until the end request.
// ----------------------------------------------------------------------------
module byte_range_spec_parser_core #(
	parameter int OFFSET_WIDTH = brsp_pkg::OFFSET_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  brsp_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output brsp_pkg::rsp_t  rsp
);

	brsp_pkg::req_t  req_s1;
	logic            valid_s1;
	logic            room, go, take;
	brsp_pkg::push_t push;

	assign req_stall = valid_s1 && !room;
	assign go        = valid_s1 && room;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk) begin
		if (take)
			req_s1 <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (go)
			valid_s1 <= 1'b0;
	end

	brsp_parse #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.req    (req_s1),
		.push   (push)
	);

	brsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

### tb/tb_byte_range_spec_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte-range spec parser core testbench
// Feeds range values one character per request, with random idling on both
// channels, and predicts every result with an in-bench parser model. Results
// are checked field by field, in order, as they leave the core.
// ----------------------------------------------------------------------------
module tb_byte_range_spec_parser_core;
	import brsp_pkg::*;

	localparam int          OFFSET_W     = OFFSET_WIDTH_DEF;
	localparam int          IDLE_PCT     = 18;
	localparam int          ITEMS_TARGET = 1500;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          TAIL_CYCLES  = 8;
	localparam logic [47:0] PREFIX_TEXT  = "bytes=";

	typedef enum logic [2:0] {
		PH_PREFIX, PH_START, PH_TAIL, PH_FIRST, PH_DASHED, PH_SECOND, PH_ERROR
	} parse_phase_e;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	byte_range_spec_parser_core #(
		.OFFSET_WIDTH(OFFSET_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// parser state as predicted
	parse_phase_e parser_phase;
	logic [2:0]   prefix_matched;
	logic [63:0]  range_start;
	logic [63:0]  range_stop;
	logic         start_given;
	logic         stop_given;

	rsp_t        pending_results[$];
	logic [7:0]  value_text[$];
	rsp_t        want;
	bit          calm = 1'b0;
	int          failures = 0;
	int          chars_parsed = 0;
	int          values_sent = 0;
	int          results_checked = 0;
	int          quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_range();
		range_start = '0;
		range_stop  = '0;
		start_given = 1'b0;
		stop_given  = 1'b0;
	endfunction

	function automatic void reset_parser();
		prefix_matched = '0;
		parser_phase   = PH_PREFIX;
		clear_range();
	endfunction

	function automatic logic [63:0] push_digit(logic [63:0] acc, logic [3:0] d);
		logic [63:0] top;
		top = (64'd1 << OFFSET_W) - 64'd1;
		if (acc > (top - 64'(d)) / 64'd10)
			return top;
		return acc * 64'd10 + 64'(d);
	endfunction

	function automatic void queue_result(logic [1:0] kind, logic last);
		rsp_t r;
		r = '0;
		r.result_kind = kind;
		r.last_result = last;
		if (kind == KIND_RANGE) begin
			r.start_present = start_given;
			r.start_offset  = start_given ? range_start[OUT_OFFSET_W-1:0] : '0;
			r.stop_present  = stop_given;
			r.stop_offset   = stop_given ? range_stop[OUT_OFFSET_W-1:0] : '0;
		end
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void put_char(input logic [7:0] ch);
		value_text.insert(value_text.size(), ch);
	endfunction

	// advances the predicted parser by one request; 0 when the request is dropped
	function automatic bit parse_char(req_t item);
		logic [7:0] c;
		logic [7:0] lc;
		logic       is_digit;
		logic [3:0] d;
		bit         bad;
		c        = item.text_byte;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d        = is_digit ? 4'(c - CH_ZERO) : 4'd0;
		bad      = 1'b0;
		if (item.end_of_text) begin
			if (parser_phase == PH_DASHED || parser_phase == PH_SECOND) begin
				queue_result(KIND_RANGE, 1'b0);
				queue_result(KIND_ACCEPT, 1'b1);
			end else if (parser_phase != PH_ERROR) begin
				queue_result(KIND_REJECT, 1'b1);
			end
			reset_parser();
			return 1'b1;
		end
		case (parser_phase)
			PH_PREFIX: begin
				lc = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
				if (prefix_matched < PREFIX_LEN &&
				    lc == PREFIX_TEXT[8*(5-int'(prefix_matched)) +: 8]) begin
					prefix_matched = prefix_matched + 3'd1;
					if (prefix_matched == PREFIX_LEN)
						parser_phase = PH_START;
				end else begin
					bad = 1'b1;
				end
			end
			PH_START: begin
				clear_range();
				if (c == CH_DASH) begin
					parser_phase = PH_TAIL;
				end else if (is_digit) begin
					start_given  = 1'b1;
					range_start  = 64'(d);
					parser_phase = PH_FIRST;
				end else begin
					bad = 1'b1;
				end
			end
			PH_TAIL: begin
				if (is_digit) begin
					stop_given   = 1'b1;
					range_stop   = 64'(d);
					parser_phase = PH_SECOND;
				end else begin
					bad = 1'b1;
				end
			end
			PH_FIRST: begin
				if (c == CH_DASH)
					parser_phase = PH_DASHED;
				else if (is_digit)
					range_start = push_digit(range_start, d);
				else
					bad = 1'b1;
			end
			PH_DASHED, PH_SECOND: begin
				if (c == CH_COMMA) begin
					queue_result(KIND_RANGE, 1'b1);
					clear_range();
					parser_phase = PH_START;
				end else if (is_digit && parser_phase == PH_DASHED) begin
					stop_given   = 1'b1;
					range_stop   = 64'(d);
					parser_phase = PH_SECOND;
				end else if (is_digit) begin
					range_stop = push_digit(range_stop, d);
				end else begin
					bad = 1'b1;
				end
			end
			default: return 1'b0;
		endcase
		if (bad) begin
			parser_phase = PH_ERROR;
			queue_result(KIND_REJECT, 1'b1);
		end
		return 1'b1;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic eot);
		req_t item;
		item.text_byte   = ch;
		item.end_of_text = eot;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		if (parse_char(item))
			chars_parsed++;
	endtask

	task automatic send_value(input logic [7:0] end_byte);
		foreach (value_text[i])
			send_char(value_text[i], 1'b0);
		send_char(end_byte, 1'b1);
		value_text.delete();
		values_sent++;
	endtask

	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic append_number();
		int len;
		case ($urandom_range(9))
			0:       len = $urandom_range(17, 22);
			1:       len = 0;
			default: len = $urandom_range(1, 3);
		endcase
		if (len == 0)
			append_text("99999999999999999999");
		for (int i = 0; i < len; i++)
			put_char(CH_ZERO + 8'($urandom_range(9)));
	endtask

	function automatic logic [7:0] syntax_char();
		case ($urandom_range(3))
			0:       return CH_DASH;
			1:       return CH_COMMA;
			2:       return CH_ZERO + 8'($urandom_range(9));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic drain_pause();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic build_value();
		logic [7:0] ch;
		int         ranges;
		int         mode;
		int         cut;
		for (int i = 0; i < PREFIX_LEN; i++) begin
			ch = PREFIX_TEXT[8*(5-i) +: 8];
			if (i < PREFIX_LEN - 1 && $urandom_range(1))
				ch = ch & ~CASE_BIT;
			put_char(ch);
		end
		ranges = $urandom_range(1, 4);
		for (int r = 0; r < ranges; r++) begin
			if (r != 0)
				put_char(CH_COMMA);
			case ($urandom_range(2))
				0: begin
					append_number();
					put_char(CH_DASH);
					append_number();
				end
				1: begin
					append_number();
					put_char(CH_DASH);
				end
				default: begin
					put_char(CH_DASH);
					append_number();
				end
			endcase
		end
		mode = $urandom_range(99);
		if (mode >= 70 && mode < 80) begin
			value_text.insert($urandom_range(value_text.size()), syntax_char());
		end else if (mode >= 80 && mode < 90) begin
			cut = $urandom_range(value_text.size() - 1);
			while (value_text.size() > cut)
				void'(value_text.pop_back());
		end else if (mode >= 90 && mode < 95) begin
			put_char(CH_COMMA);
		end else if (mode >= 95) begin
			value_text.delete();
			repeat ($urandom_range(8))
				put_char(syntax_char());
		end
	endtask

	task automatic test_range_forms();
		append_text("bYtEs=10-9,-5,7-");
		send_value(8'hff);
	endtask

	task automatic test_errors();
		// end inside prefix, prefix mismatch, bad character after a dash
		send_value(8'h00);
		append_text("by");
		send_value(8'h7f);
		put_char(8'h80);
		put_char(8'h00);
		send_value(8'h2d);
		append_text("bytes=1-x5");
		send_value(8'h00);
	endtask

	task automatic test_saturation();
		append_text("bytes=9223372036854775807-9223372036854775808,-99999999999999999999");
		send_value(8'h00);
	endtask

	task automatic test_drain_pause();
		append_text("BYTES=0-0,5-");
		send_value(8'h00);
		drain_pause();
		append_text("bytes=-1");
		send_value(8'h00);
	endtask

	task automatic test_random();
		int n;
		n = 0;
		while (chars_parsed < ITEMS_TARGET) begin
			calm = (n >= 10 && n < 30);
			build_value();
			send_value(8'($urandom_range(255)));
			if ($urandom_range(19) == 0)
				drain_pause();
			n++;
		end
		calm = 1'b0;
	endtask

	always @(posedge clk)
		rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);

	task automatic check_field(input string name, input logic [62:0] exp_v,
	                           input logic [62:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("result_kind: expected none, actual %0d", rsp.result_kind);
				failures++;
			end else begin
				want = pending_results.pop_front();
				check_field("result_kind", 63'(want.result_kind), 63'(rsp.result_kind));
				check_field("start_present", 63'(want.start_present),
				            63'(rsp.start_present));
				check_field("start_offset", want.start_offset, rsp.start_offset);
				check_field("stop_present", 63'(want.stop_present), 63'(rsp.stop_present));
				check_field("stop_offset", want.stop_offset, rsp.stop_offset);
				check_field("last_result", 63'(want.last_result), 63'(rsp.last_result));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		reset_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_range_forms();
		test_errors();
		test_saturation();
		test_drain_pause();
		test_random();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			failures++;
		end
		$display("Sent %0d range values (%0d parsed requests): all three range forms,",
		         values_sent, chars_parsed);
		$display("errors, truncations and saturation; %0d results checked, %0d mismatches.",
		         results_checked, failures);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
